FILE: src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while reset is low.
`define MBE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mbe assertion failed");

// Same, on the block clock and reset.
`define MBE_ASSERT_CLK(lbl, prop) `MBE_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

FILE: src/mbe_pkg.sv
`timescale 1ns / 1ps

package mbe_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 27;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int CNT_W      = 12;
    localparam int IDX_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int ROW_LIMIT = 4096;
    localparam int COL_LIMIT = 4096;

    localparam logic [PROD_W-1:0] ESCAPE_BOUND = 64'd4 << (2 * FRAC_BITS);

    localparam logic signed [COORD_W-1:0] MIN_X_RST  = -32'sd281857229;
    localparam logic signed [COORD_W-1:0] MIN_Y_RST  = -32'sd167772160;
    localparam logic signed [COORD_W-1:0] STEP_X_RST = 32'sd367002;
    localparam logic signed [COORD_W-1:0] STEP_Y_RST = 32'sd327680;
    localparam logic [CNT_W-1:0]          MAX_IT_RST = 12'd511;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_X,
        ST_MAP_Y,
        ST_SET_C,
        ST_SQ_X,
        ST_SQ_Y,
        ST_CHECK,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

endpackage

FILE: src/mbe_if.sv
`timescale 1ns / 1ps

interface mbe_pix_if;
    import mbe_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    modport source (output valid, output row, output col, input ready);
    modport sink   (input valid, input row, input col, output ready);
endinterface

interface mbe_res_if;
    import mbe_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] iterations;
    logic [IDX_W-1:0] row_out;
    logic [IDX_W-1:0] col_out;
    modport source (output valid, output iterations, output row_out, output col_out,
                    input ready);
    modport sink   (input valid, input iterations, input row_out, input col_out,
                    output ready);
endinterface

interface mbe_cfg_if;
    import mbe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                          Transaction
// i_cfg    in   index[2:0], data[31:0]          valid & ready (ready high out of reset)
// i_pix    in   row[11:0], col[11:0]            valid & ready
// o_res    out  iterations, row_out, col_out    valid & ready
//
// Each pixel runs n iterations before the next accept, n being the
// iteration count (at most max_iter): one shared 32x32 multiplier forms three
// products per iteration. i_pix.ready is high only while idle.
// Results sit in an output register; a held result stalls only the next finish.
// Synchronous active-low reset restores the register defaults.

module mandelbrot_escape_time_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbe_cfg_if.sink   i_cfg,
    mbe_pix_if.sink   i_pix,
    mbe_res_if.source o_res
);
    import mbe_pkg::*;

    t_state r_state;
    t_state n_state;

    logic signed [COORD_W-1:0] r_min_x;
    logic signed [COORD_W-1:0] r_min_y;
    logic signed [COORD_W-1:0] r_step_x;
    logic signed [COORD_W-1:0] r_step_y;
    logic [CNT_W-1:0]          r_max_iter;

    logic [IDX_W-1:0]          r_row;
    logic [IDX_W-1:0]          r_col;
    logic [IDX_W-1:0]          n_row;
    logic [IDX_W-1:0]          n_col;
    logic signed [COORD_W-1:0] r_c_real;
    logic signed [COORD_W-1:0] r_c_imag;
    logic signed [COORD_W-1:0] r_z_real;
    logic signed [COORD_W-1:0] r_z_imag;
    logic [CNT_W-1:0]          r_iter;

    logic signed [COORD_W-1:0] mul_a;
    logic signed [COORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_xx;
    logic signed [PROD_W-1:0]  r_diff;
    logic [PROD_W-1:0]         mag_sq;
    logic                      stop;

    logic                      r_out_valid;
    logic [CNT_W-1:0]          r_out_iter;
    logic [IDX_W-1:0]          r_out_row;
    logic [IDX_W-1:0]          r_out_col;
    logic                      out_free;
    logic                      in_fire;
    logic                      load_out;

    assign i_cfg.ready = i_rst_n;
    assign i_pix.ready = i_rst_n && (r_state == ST_IDLE);
    assign in_fire     = i_pix.valid && i_pix.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    assign o_res.valid      = r_out_valid;
    assign o_res.iterations = r_out_iter;
    assign o_res.row_out    = r_out_row;
    assign o_res.col_out    = r_out_col;

    always_comb begin
        n_row = i_pix.row;
        n_col = i_pix.col;
        if (32'(i_pix.row) >= ROW_LIMIT) begin
            n_row = IDX_W'(ROW_LIMIT - 1);
        end
        if (32'(i_pix.col) >= COL_LIMIT) begin
            n_col = IDX_W'(COL_LIMIT - 1);
        end
    end

    assign mul_p  = mul_a * mul_b;
    assign mag_sq = unsigned'(r_xx) + unsigned'(r_prod);
    assign stop   = (r_iter >= r_max_iter) || (mag_sq >= ESCAPE_BOUND);

    always_comb begin
        n_state  = r_state;
        mul_a    = r_z_real;
        mul_b    = r_z_real;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_MAP_X;
                end
            end
            ST_MAP_X: begin
                mul_a   = signed'(COORD_W'(r_col));
                mul_b   = r_step_x;
                n_state = ST_MAP_Y;
            end
            ST_MAP_Y: begin
                mul_a   = signed'(COORD_W'(r_row));
                mul_b   = r_step_y;
                n_state = ST_SET_C;
            end
            ST_SET_C: begin
                n_state = ST_SQ_X;
            end
            ST_SQ_X: begin
                n_state = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                mul_a   = r_z_imag;
                mul_b   = r_z_imag;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                mul_b   = r_z_imag;
                n_state = stop ? ST_FINISH : ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = ST_SQ_X;
            end
            ST_FINISH: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x    <= MIN_X_RST;
            r_min_y    <= MIN_Y_RST;
            r_step_x   <= STEP_X_RST;
            r_step_y   <= STEP_Y_RST;
            r_max_iter <= MAX_IT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_MIN_X:    r_min_x    <= signed'(i_cfg.data);
                REG_MIN_Y:    r_min_y    <= signed'(i_cfg.data);
                REG_STEP_X:   r_step_x   <= signed'(i_cfg.data);
                REG_STEP_Y:   r_step_y   <= signed'(i_cfg.data);
                REG_MAX_ITER: r_max_iter <= i_cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath around the shared multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_row <= n_row;
                    r_col <= n_col;
                end
            end
            ST_MAP_Y: begin
                r_c_real <= sat32(PROD_W'(r_min_x) + r_prod);
            end
            ST_SET_C: begin
                r_c_imag <= sat32(PROD_W'(r_min_y) + r_prod);
                r_z_real <= r_c_real;
                r_z_imag <= sat32(PROD_W'(r_min_y) + r_prod);
                r_iter   <= '0;
            end
            ST_SQ_Y: begin
                r_xx <= r_prod;
            end
            ST_CHECK: begin
                r_diff <= r_xx - r_prod;
            end
            ST_UPDATE: begin
                r_z_real <= sat32((r_diff >>> FRAC_BITS) + PROD_W'(r_c_real));
                r_z_imag <= sat32((r_prod >>> (FRAC_BITS - 1)) + PROD_W'(r_c_imag));
                r_iter   <= r_iter + CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_iter <= r_iter;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
        end
    end

endmodule

FILE: src/mbe_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbe_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [mbe_pkg::CNT_W-1:0] i_out_iter,
    input logic [mbe_pkg::IDX_W-1:0] i_out_row,
    input logic [mbe_pkg::IDX_W-1:0] i_out_col
);
    import mbe_pkg::*;

    logic [CNT_W+2*IDX_W-1:0] out_payload;

    assign out_payload = {i_out_iter, i_out_row, i_out_col};

    `MBE_ASSERT_CLK(a_out_hold_valid, i_out_valid && !i_out_ready |=> i_out_valid)
    `MBE_ASSERT_CLK(a_out_hold_data, i_out_valid && !i_out_ready |=> $stable(out_payload))
    `MBE_ASSERT_CLK(a_busy_after_accept, i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
    `MBE_ASSERT_CLK(a_result_from_work, $rose(i_out_valid) |-> $past(!i_in_ready))

endmodule

bind mandelbrot_escape_time_unit mbe_checker u_mbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_iter  (o_res.iterations),
    .i_out_row   (o_res.row_out),
    .i_out_col   (o_res.col_out)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mbe_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    // indexes outside the register map, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum logic {STIM_REG, STIM_PIXEL} t_stim_kind;

    typedef enum {WIN_DEFAULT, WIN_INTERIOR, WIN_SENSIBLE, WIN_RANDOM, WIN_CORNER} t_window;

    typedef struct packed {
        t_stim_kind            kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic                  known;
        logic [CNT_W-1:0]      iters;
    } t_stim_row;

    typedef struct packed {
        logic [CNT_W-1:0] iters;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_px_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbe_cfg_if cfg_bus ();
    mbe_pix_if pix_bus ();
    mbe_res_if res_bus ();

    mandelbrot_escape_time_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_res   (res_bus)
    );

    always #5 i_clk = ~i_clk;

    // local copy of the register file
    int               min_x_q;
    int               min_y_q;
    int               step_x_q;
    int               step_y_q;
    logic [CNT_W-1:0] iter_lim;

    t_px_result owed_pixels[$];
    t_px_result want;
    int         mismatches = 0;
    int         cycle_count = 0;
    bit         calm = 1'b0;

    t_stim_row dir_table [30] = '{
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd0,    12'd0,    1'b1, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd4095, 12'd4095, 1'b1, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd512,  12'd770,  1'b0, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd0,    12'd4095, 1'b0, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd4095, 12'd0,    1'b0, 12'd0},
        '{STIM_REG,   REG_MAX_ITER, 32'h0,        12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd512,  12'd770,  1'b1, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd4095, 12'd4095, 1'b1, 12'd0},
        '{STIM_REG,   REG_MAX_ITER, 32'h1,        12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_REG,   REG_SPARE_5,  32'hFFFFFFFF, 12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_REG,   REG_SPARE_7,  32'hFFFFFFFF, 12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd512,  12'd770,  1'b1, 12'd1},
        '{STIM_REG,   REG_MIN_X,    32'h7FFFFFFF, 12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_REG,   REG_STEP_X,   32'h7FFFFFFF, 12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_REG,   REG_MIN_Y,    32'h80000000, 12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_REG,   REG_STEP_Y,   32'h80000000, 12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_REG,   REG_MAX_ITER, 32'hFFF,      12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd4095, 12'd4095, 1'b1, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd0,    12'd0,    1'b1, 12'd0},
        '{STIM_REG,   REG_MIN_X,    32'h0,        12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_REG,   REG_MIN_Y,    32'h0,        12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_REG,   REG_STEP_X,   32'h0,        12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_REG,   REG_STEP_Y,   32'h0,        12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd4095, 12'd4095, 1'b1, 12'd4095},
        '{STIM_REG,   REG_MIN_X,    32'hF0000000, 12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd100,  12'd200,  1'b1, 12'd0},
        '{STIM_REG,   REG_MIN_X,    32'hF0000001, 12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_REG,   REG_MIN_X,    32'hE0000000, 12'd0,    12'd0,    1'b0, 12'd0},
        '{STIM_PIXEL, REG_MIN_X,    32'h0,        12'd7,    12'd9,    1'b1, 12'd0}
    };

    function automatic int saturate_q527(input longint v);
        if (v > Q_MAX) begin
            return int'(Q_MAX);
        end
        if (v < Q_MIN) begin
            return int'(Q_MIN);
        end
        return int'(v);
    endfunction

    function automatic logic [CNT_W-1:0] escape_count(input logic [IDX_W-1:0] r,
                                                      input logic [IDX_W-1:0] c);
        int                cr;
        int                ci;
        int                zr;
        int                zi;
        longint            xx;
        longint            yy;
        longint            xy;
        longint unsigned   mag;
        int unsigned       n;
        cr = saturate_q527(longint'(min_x_q) + longint'(c) * longint'(step_x_q));
        ci = saturate_q527(longint'(min_y_q) + longint'(r) * longint'(step_y_q));
        zr = cr;
        zi = ci;
        n = 0;
        while (n < iter_lim) begin
            xx = longint'(zr) * longint'(zr);
            yy = longint'(zi) * longint'(zi);
            xy = longint'(zr) * longint'(zi);
            mag = longint'(xx) + longint'(yy);
            if (mag >= ESCAPE_BOUND) begin
                break;
            end
            zr = saturate_q527(((xx - yy) >>> FRAC_BITS) + longint'(cr));
            zi = saturate_q527((xy >>> (FRAC_BITS - 1)) + longint'(ci));
            n++;
        end
        return n[CNT_W-1:0];
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MIN_X:    min_x_q = int'(data);
            REG_MIN_Y:    min_y_q = int'(data);
            REG_STEP_X:   step_x_q = int'(data);
            REG_STEP_Y:   step_y_q = int'(data);
            REG_MAX_ITER: iter_lim = data[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int corner_value();
        case ($urandom_range(0, 4))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 0;
            3: return 1;
            default: return -1;
        endcase
    endfunction

    task automatic wait_drained();
        pix_bus.valid <= 1'b0;
        while (owed_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int n);
        pix_bus.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        apply_reg(idx, data);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                              input logic known, input logic [CNT_W-1:0] iters);
        t_px_result owed;
        pix_bus.valid <= 1'b1;
        pix_bus.row   <= r;
        pix_bus.col   <= c;
        do @(posedge i_clk); while (!pix_bus.ready);
        owed.row   = (int'(r) >= ROW_LIMIT) ? IDX_W'(ROW_LIMIT - 1) : r;
        owed.col   = (int'(c) >= COL_LIMIT) ? IDX_W'(COL_LIMIT - 1) : c;
        owed.iters = known ? iters : escape_count(owed.row, owed.col);
        owed_pixels.push_back(owed);
    endtask

    task automatic program_window(input int mx, input int my, input int sx, input int sy,
                                  input logic [CNT_W-1:0] lim);
        write_reg(REG_MIN_X, mx);
        write_reg(REG_MIN_Y, my);
        write_reg(REG_STEP_X, sx);
        write_reg(REG_STEP_Y, sy);
        write_reg(REG_MAX_ITER, CFG_DATA_W'(lim));
    endtask

    task automatic run_phase(input int count, input t_window mode, input logic [CNT_W-1:0] lim);
        int               sx;
        int               sy;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        case (mode)
            WIN_DEFAULT, WIN_INTERIOR: begin
                program_window(MIN_X_RST, MIN_Y_RST, STEP_X_RST, STEP_Y_RST, lim);
            end
            WIN_SENSIBLE: begin
                sx = int'($urandom_range(0, 1 << 19));
                sy = int'($urandom_range(0, 1 << 19));
                if ($urandom_range(0, 3) == 0) begin
                    sx = -sx;
                end
                if ($urandom_range(0, 3) == 0) begin
                    sy = -sy;
                end
                program_window(int'($urandom_range(0, 3 << 27)) - (5 << 26),
                               int'($urandom_range(0, 2 << 27)) - (3 << 26), sx, sy, lim);
            end
            WIN_RANDOM: begin
                program_window(int'($urandom), int'($urandom), int'($urandom),
                               int'($urandom), lim);
            end
            default: begin
                program_window(corner_value(), corner_value(), corner_value(),
                               corner_value(), lim);
            end
        endcase
        for (int k = 0; k < count; k++) begin
            if (mode == WIN_INTERIOR) begin
                r = IDX_W'($urandom_range(400, 624));
                c = IDX_W'($urandom_range(600, 800));
            end else if ($urandom_range(0, 4) == 0) begin
                r = IDX_W'($urandom);
                c = IDX_W'($urandom);
            end else begin
                r = IDX_W'($urandom_range(0, 1023));
                c = IDX_W'($urandom_range(0, 1023));
            end
            send_pixel(r, c, 1'b0, '0);
            if (!calm) begin
                if ($urandom_range(0, 39) == 0) begin
                    wait_drained();
                end else if ($urandom_range(0, 3) == 0) begin
                    pause_sender($urandom_range(1, 14));
                end
            end
        end
    endtask

    initial begin
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (calm) begin
                res_bus.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                res_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (owed_pixels.size() == 0) begin
                $display("%0t: unexpected result: expected none, got iters %0d row %0d col %0d",
                         $time, res_bus.iterations, res_bus.row_out, res_bus.col_out);
                mismatches++;
            end else begin
                want = owed_pixels.pop_front();
                if (res_bus.iterations !== want.iters) begin
                    $display("%0t: iterations (%0d,%0d): expected %0d, got %0d", $time,
                             want.row, want.col, want.iters, res_bus.iterations);
                    mismatches++;
                end
                if (res_bus.row_out !== want.row) begin
                    $display("%0t: row_out: expected %0d, got %0d", $time,
                             want.row, res_bus.row_out);
                    mismatches++;
                end
                if (res_bus.col_out !== want.col) begin
                    $display("%0t: col_out: expected %0d, got %0d", $time,
                             want.col, res_bus.col_out);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_window mode;
        i_rst_n       <= 1'b0;
        pix_bus.valid <= 1'b0;
        pix_bus.row   <= '0;
        pix_bus.col   <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= '0;
        cfg_bus.data  <= '0;
        min_x_q  = MIN_X_RST;
        min_y_q  = MIN_Y_RST;
        step_x_q = STEP_X_RST;
        step_y_q = STEP_Y_RST;
        iter_lim = MAX_IT_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < $size(dir_table); i++) begin
            if (dir_table[i].kind == STIM_REG) begin
                write_reg(dir_table[i].idx, dir_table[i].data);
            end else begin
                send_pixel(dir_table[i].row, dir_table[i].col, dir_table[i].known,
                           dir_table[i].iters);
            end
        end

        run_phase(100, WIN_DEFAULT, MAX_IT_RST);
        run_phase(12, WIN_INTERIOR, 12'd4095);
        for (int i = 0; i < 7; i++) begin
            mode = (i % 2 == 0) ? WIN_SENSIBLE : ((i % 4 == 1) ? WIN_RANDOM : WIN_CORNER);
            run_phase(130, mode, (i == 2) ? 12'd1 : CNT_W'($urandom_range(2, 80)));
        end
        calm = 1'b1;
        run_phase(130, WIN_SENSIBLE, 12'd64);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && owed_pixels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/mbe_pkg.sv
src/mbe_if.sv
src/mandelbrot_escape_time_unit.sv
src/mbe_checker.sv
sim/tb_top.sv
